// File: rtl/snc_pkg.sv
// Shared types, constants and helpers for the nest choice event engine.
package snc_pkg;

	localparam int MAX_ANTS  = 1023;
	localparam int CNT_W     = 10;                 // population counter width
	localparam int RATE_W    = 16;                 // Q0.16 rate and fraction width
	localparam int RW_W      = 32;                 // random word width
	localparam int TOT_W     = 48;                 // scaled rate sum width
	localparam int PROD_W    = RW_W + 1 + TOT_W;   // (2r+1) * total
	localparam int MA_W      = 32;                 // multiplier operand widths
	localparam int MB_W      = 26;
	localparam int MP_W      = MA_W + MB_W;
	localparam int NUM_EV    = 15;
	localparam int EV_W      = 4;
	localparam int SEQ_W     = 4;
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 80;

	localparam logic [SEQ_W-1:0] INIT_LAST = SEQ_W'(5);
	localparam logic [SEQ_W-1:0] PRE_LAST  = SEQ_W'(3);
	localparam logic [SEQ_W-1:0] TERM_LAST = SEQ_W'(NUM_EV);
	localparam logic [SEQ_W-1:0] PROD_LAST = SEQ_W'(2);

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	typedef enum logic [2:0] {
		REG_COMMIT,
		REG_SWITCH,
		REG_LEAK,
		REG_ANTS,
		REG_HIGH,
		REG_START,
		REG_QUORUM
	} reg_idx_t;

	typedef enum logic [1:0] {
		OC_RUNNING,
		OC_GOOD,
		OC_POOR,
		OC_HOME
	} outcome_t;

	typedef enum logic [EV_W-1:0] {
		EV_LH_TO_LPC,
		EV_HH_TO_HPV,
		EV_LH_TO_LGC,
		EV_HH_TO_HGC,
		EV_LPC_TO_LPR,
		EV_LGC_TO_LGR,
		EV_HGC_TO_HGR,
		EV_HPV_TO_HGC,
		EV_LPC_TO_LH,
		EV_HPV_TO_HH,
		EV_LPR_TO_LH,
		EV_LGC_TO_LH,
		EV_HGC_TO_HH,
		EV_LGR_TO_LH,
		EV_HGR_TO_HH,
		EV_NONE
	} ev_code_t;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_INIT,
		SQ_FIX,
		SQ_PRE,
		SQ_TERM,
		SQ_PROD,
		SQ_CMP,
		SQ_MOVE,
		SQ_STATUS,
		SQ_DONE
	} seq_state_t;

	typedef struct packed {
		logic [RATE_W-1:0] rate_commit;
		logic [RATE_W-1:0] rate_switch;
		logic [RATE_W-1:0] rate_leak;
		logic [CNT_W-1:0]  ant_count;
		logic [RATE_W-1:0] high_fraction;
		logic [RATE_W-1:0] start_fraction;
		logic [CNT_W-1:0]  quorum_count;
	} cfg_t;

	function automatic logic [CNT_W-1:0] eff_ants(input logic [CNT_W-1:0] n);
		if (int'(n) > MAX_ANTS) begin
			return CNT_W'(MAX_ANTS);
		end
		return n;
	endfunction

endpackage

// File: rtl/stochastic_nest_choice_step_unit.sv
// Top level of the stochastic nest choice event engine.
//
//  channel   | direction | carries
//  ----------+-----------+--------------------------------------------------------
//  s_axis    | in        | tuser: cmd (start/step); tdata: random_word
//  m_axis    | out       | tdata: event_index, outcome, good_total, poor_total, total_rate
//  apb       | in        | seven configuration registers at 4-byte spacing
//
//  A start transaction runs five multiplies for the initial split, then the
//  remainder fix and the status update.
//  A step in a running trial runs 3 rate*count multiplies, 15 term multiplies,
//  two partial products of (2r+1)*total, then one compare a cycle until the event
//  is found or all fifteen are compared; all go through one 32x26 multiplier. A
//  step with no running trial goes straight to the result.
//  Each result returns the engine to idle before the next accept. A finished result
//  waits in the output register; the next transaction may be taken meanwhile, and
//  its result holds the engine until that register is free.
//  Reset is asynchronous; after it no trial runs and all counters are zero.
module stochastic_nest_choice_step_unit
	import snc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [31:0] random_word
	input  logic                 s_axis_tuser,   // [0] cmd
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [3:0] event_index, [5:4] outcome, [15:6] good_total, [25:16] poor_total,
	// [73:26] total_rate, [79:74] zero
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [APB_AW-1:0]    paddr,
	input  logic [APB_DW-1:0]    pwdata,
	output logic [APB_DW-1:0]    prdata,
	output logic                 pready
);

	cfg_t            cfg;
	logic [MA_W-1:0] mul_a;
	logic [MB_W-1:0] mul_b;
	logic [MP_W-1:0] mul_p;

	snc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	snc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	snc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.in_word   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.mul_a     (mul_a),
		.mul_b     (mul_b),
		.mul_p     (mul_p)
	);

endmodule

// File: rtl/snc_apb_regs.sv
// Configuration register file behind the APB port.
module snc_apb_regs
	import snc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_commit    <= RATE_W'(6554);
			cfg_q.rate_switch    <= RATE_W'(6554);
			cfg_q.rate_leak      <= RATE_W'(3277);
			cfg_q.ant_count      <= CNT_W'(100);
			cfg_q.high_fraction  <= RATE_W'(13107);
			cfg_q.start_fraction <= RATE_W'(19661);
			cfg_q.quorum_count   <= CNT_W'(50);
		end else if (wr_en) begin
			case (idx)
				REG_COMMIT: cfg_q.rate_commit    <= pwdata[RATE_W-1:0];
				REG_SWITCH: cfg_q.rate_switch    <= pwdata[RATE_W-1:0];
				REG_LEAK:   cfg_q.rate_leak      <= pwdata[RATE_W-1:0];
				REG_ANTS:   cfg_q.ant_count      <= pwdata[CNT_W-1:0];
				REG_HIGH:   cfg_q.high_fraction  <= pwdata[RATE_W-1:0];
				REG_START:  cfg_q.start_fraction <= pwdata[RATE_W-1:0];
				REG_QUORUM: cfg_q.quorum_count   <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_COMMIT: prdata = APB_DW'(cfg_q.rate_commit);
			REG_SWITCH: prdata = APB_DW'(cfg_q.rate_switch);
			REG_LEAK:   prdata = APB_DW'(cfg_q.rate_leak);
			REG_ANTS:   prdata = APB_DW'(cfg_q.ant_count);
			REG_HIGH:   prdata = APB_DW'(cfg_q.high_fraction);
			REG_START:  prdata = APB_DW'(cfg_q.start_fraction);
			REG_QUORUM: prdata = APB_DW'(cfg_q.quorum_count);
			default:    prdata = '0;
		endcase
	end

endmodule

// File: rtl/snc_mul.sv
// Shared 32x26 unsigned multiplier with a registered product.
module snc_mul
	import snc_pkg::*;
(
	input  logic            clk,
	input  logic [MA_W-1:0] a,
	input  logic [MB_W-1:0] b,
	output logic [MP_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= MP_W'(a) * MP_W'(b);
	end

endmodule

// File: rtl/snc_engine.sv
// Sequencer and datapath: trial loading, rate sum, event pick and population update.
module snc_engine
	import snc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_cmd,
	input  logic [RW_W-1:0]      in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [M_TDATA_W-1:0] out_data,
	output logic [MA_W-1:0]      mul_a,
	output logic [MB_W-1:0]      mul_b,
	input  logic [MP_W-1:0]      mul_p
);

	seq_state_t state_q, state_d;
	logic [SEQ_W-1:0] cnt_q;

	// populations
	logic [CNT_W-1:0] lh_q, hh_q, lpc_q, lpr_q, hpv_q, lgc_q, hgc_q, lgr_q, hgr_q;
	outcome_t status_q, status_new;
	logic     out_valid_q;

	// payload
	ev_code_t               ev_q;
	logic [RW_W-1:0]        word_q;
	logic [MB_W-1:0]        nh_q, cn_q, wn_q, kn_q;
	logic [TOT_W-1:0]       tot_q;
	logic [TOT_W-1:0]       cum_q [NUM_EV];
	logic [PROD_W-1:0]      acc_q;
	logic [M_TDATA_W-1:0]   out_data_q;

	logic [CNT_W-1:0]  n_eff;
	logic [CNT_W:0]    grec;
	logic [CNT_W:0]    home_sum;
	logic [CNT_W+1:0]  good_sum, poor_sum;
	logic [CNT_W+2:0]  fix_sum;
	logic [RATE_W:0]   one_minus_s;
	logic [CNT_W-1:0]  hsplit;
	logic              term_shift;
	logic [TOT_W-1:0]  term_val, tot_next;
	logic [TOT_W-1:0]  cum_rd;
	logic              hit, accept, load_out;

	assign n_eff       = eff_ants(cfg.ant_count);
	assign grec        = {1'b0, lgr_q} + {1'b0, hgr_q};
	assign home_sum    = {1'b0, lh_q} + {1'b0, hh_q};
	assign good_sum    = (CNT_W+2)'(lgc_q) + (CNT_W+2)'(hgc_q) + (CNT_W+2)'(lgr_q)
		+ (CNT_W+2)'(hgr_q);
	assign poor_sum    = (CNT_W+2)'(lpc_q) + (CNT_W+2)'(lpr_q) + (CNT_W+2)'(hpv_q);
	assign fix_sum     = (CNT_W+3)'(hh_q) + (CNT_W+3)'(lh_q) + (CNT_W+3)'(hpv_q)
		+ (CNT_W+3)'(lpc_q) + (CNT_W+3)'(hgc_q) + (CNT_W+3)'(lgc_q);
	assign one_minus_s = (RATE_W+1)'(1 << RATE_W) - {1'b0, cfg.start_fraction};
	assign hsplit      = mul_p[33+CNT_W-1:33];

	// the four recruitment terms carry an extra 2^16
	assign term_shift  = (cnt_q >= SEQ_W'(1)) && (cnt_q <= SEQ_W'(4));
	assign term_val    = term_shift ? {mul_p[TOT_W-17:0], 16'b0} : mul_p[TOT_W-1:0];
	assign tot_next    = tot_q + term_val;
	assign cum_rd      = cum_q[cnt_q];
	assign hit         = acc_q < {cum_rd, (RW_W+1)'(0)};

	always_comb begin
		if (home_sum >= {1'b0, n_eff}) begin
			status_new = OC_HOME;
		end else if (good_sum >= (CNT_W+2)'(cfg.quorum_count)) begin
			status_new = OC_GOOD;
		end else if (poor_sum >= (CNT_W+2)'(cfg.quorum_count)) begin
			status_new = OC_POOR;
		end else begin
			status_new = OC_RUNNING;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: begin
				if (in_valid) begin
					if (in_cmd == CMD_START) begin
						state_d = SQ_INIT;
					end else if (status_q == OC_RUNNING) begin
						state_d = SQ_PRE;
					end else begin
						state_d = SQ_DONE;
					end
				end
			end
			SQ_INIT:   if (cnt_q == INIT_LAST) state_d = SQ_FIX;
			SQ_FIX:    state_d = SQ_STATUS;
			SQ_PRE:    if (cnt_q == PRE_LAST) state_d = SQ_TERM;
			SQ_TERM:   if (cnt_q == TERM_LAST) state_d = SQ_PROD;
			SQ_PROD:   if (cnt_q == PROD_LAST) state_d = SQ_CMP;
			SQ_CMP: begin
				if (hit) begin
					state_d = SQ_MOVE;
				end else if (cnt_q == SEQ_W'(NUM_EV - 1)) begin
					state_d = SQ_DONE;
				end
			end
			SQ_MOVE:   state_d = SQ_STATUS;
			SQ_STATUS: state_d = SQ_DONE;
			SQ_DONE:   if (!out_valid_q || out_ready) state_d = SQ_IDLE;
			default:   state_d = SQ_IDLE;
		endcase
	end

	// outputs and multiplier operand select
	always_comb begin
		in_ready = (state_q == SQ_IDLE);
		accept   = in_ready && in_valid;
		load_out = (state_q == SQ_DONE) && (!out_valid_q || out_ready);
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			SQ_INIT: begin
				case (cnt_q)
					SEQ_W'(0): begin mul_a = MA_W'(n_eff);       mul_b = MB_W'(cfg.high_fraction); end
					SEQ_W'(1): begin mul_a = MA_W'(one_minus_s); mul_b = MB_W'(n_eff); end
					SEQ_W'(2): begin mul_a = MA_W'(one_minus_s); mul_b = nh_q; end
					SEQ_W'(3): begin mul_a = MA_W'(cfg.start_fraction); mul_b = MB_W'(n_eff); end
					SEQ_W'(4): begin mul_a = MA_W'(cfg.start_fraction); mul_b = nh_q; end
					default: ;
				endcase
			end
			SQ_PRE: begin
				mul_b = MB_W'(n_eff);
				case (cnt_q)
					SEQ_W'(0): mul_a = MA_W'(cfg.rate_commit);
					SEQ_W'(1): mul_a = MA_W'(cfg.rate_switch);
					SEQ_W'(2): mul_a = MA_W'(cfg.rate_leak);
					default:   mul_a = '0;
				endcase
			end
			SQ_TERM: begin
				case (ev_code_t'(cnt_q))
					EV_LH_TO_LPC:  begin mul_a = MA_W'(lpr_q); mul_b = MB_W'(lh_q); end
					EV_HH_TO_HPV:  begin mul_a = MA_W'(lpr_q); mul_b = MB_W'(hh_q); end
					EV_LH_TO_LGC:  begin mul_a = MA_W'(grec);  mul_b = MB_W'(lh_q); end
					EV_HH_TO_HGC:  begin mul_a = MA_W'(grec);  mul_b = MB_W'(hh_q); end
					EV_LPC_TO_LPR: begin mul_a = MA_W'(lpc_q); mul_b = cn_q; end
					EV_LGC_TO_LGR: begin mul_a = MA_W'(lgc_q); mul_b = cn_q; end
					EV_HGC_TO_HGR: begin mul_a = MA_W'(hgc_q); mul_b = cn_q; end
					EV_HPV_TO_HGC: begin mul_a = MA_W'(hpv_q); mul_b = wn_q; end
					EV_LPC_TO_LH:  begin mul_a = MA_W'(lpc_q); mul_b = kn_q; end
					EV_HPV_TO_HH:  begin mul_a = MA_W'(hpv_q); mul_b = kn_q; end
					EV_LPR_TO_LH:  begin mul_a = MA_W'(lpr_q); mul_b = kn_q; end
					EV_LGC_TO_LH:  begin mul_a = MA_W'(lgc_q); mul_b = kn_q; end
					EV_HGC_TO_HH:  begin mul_a = MA_W'(hgc_q); mul_b = kn_q; end
					EV_LGR_TO_LH:  begin mul_a = MA_W'(lgr_q); mul_b = kn_q; end
					EV_HGR_TO_HH:  begin mul_a = MA_W'(hgr_q); mul_b = kn_q; end
					default: ;
				endcase
			end
			SQ_PROD: begin
				// low 32 bits of 2r+1; the top bit is added as total << 32
				mul_a = {word_q[RW_W-2:0], 1'b1};
				if (cnt_q == SEQ_W'(0)) begin
					mul_b = MB_W'(tot_q[TOT_W/2-1:0]);
				end else begin
					mul_b = MB_W'(tot_q[TOT_W-1:TOT_W/2]);
				end
			end
			default: ;
		endcase
	end

	// control and population state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_IDLE;
			cnt_q       <= '0;
			status_q    <= OC_HOME;
			out_valid_q <= 1'b0;
			lh_q  <= '0; hh_q  <= '0; lpc_q <= '0;
			lpr_q <= '0; hpv_q <= '0; lgc_q <= '0;
			hgc_q <= '0; lgr_q <= '0; hgr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + SEQ_W'(1);
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				SQ_INIT: begin
					case (cnt_q)
						SEQ_W'(0): begin
							lpr_q <= '0;
							lgr_q <= '0;
							hgr_q <= '0;
						end
						SEQ_W'(2): lh_q <= mul_p[16+CNT_W-1:16];
						SEQ_W'(3): begin
							hh_q <= mul_p[32+CNT_W-1:32];
							lh_q <= lh_q - mul_p[32+CNT_W-1:32];
						end
						SEQ_W'(4): lpc_q <= mul_p[17+CNT_W-1:17];
						SEQ_W'(5): begin
							hpv_q <= hsplit;
							hgc_q <= hsplit;
							lpc_q <= lpc_q - hsplit;
							lgc_q <= lpc_q - hsplit;
						end
						default: ;
					endcase
				end
				SQ_FIX: begin
					// remainder of the colony goes to the high-threshold ants at home
					if (fix_sum < (CNT_W+3)'(n_eff)) begin
						hh_q <= hh_q + (n_eff - fix_sum[CNT_W-1:0]);
					end
				end
				SQ_MOVE: begin
					case (ev_q)
						EV_LH_TO_LPC: begin
							lh_q  <= lh_q - CNT_W'(1);
							lpc_q <= lpc_q + CNT_W'(1);
						end
						EV_HH_TO_HPV: begin
							hh_q  <= hh_q - CNT_W'(1);
							hpv_q <= hpv_q + CNT_W'(1);
						end
						EV_LH_TO_LGC: begin
							lh_q  <= lh_q - CNT_W'(1);
							lgc_q <= lgc_q + CNT_W'(1);
						end
						EV_HH_TO_HGC: begin
							hh_q  <= hh_q - CNT_W'(1);
							hgc_q <= hgc_q + CNT_W'(1);
						end
						EV_LPC_TO_LPR: begin
							lpc_q <= lpc_q - CNT_W'(1);
							lpr_q <= lpr_q + CNT_W'(1);
						end
						EV_LGC_TO_LGR: begin
							lgc_q <= lgc_q - CNT_W'(1);
							lgr_q <= lgr_q + CNT_W'(1);
						end
						EV_HGC_TO_HGR: begin
							hgc_q <= hgc_q - CNT_W'(1);
							hgr_q <= hgr_q + CNT_W'(1);
						end
						EV_HPV_TO_HGC: begin
							hpv_q <= hpv_q - CNT_W'(1);
							hgc_q <= hgc_q + CNT_W'(1);
						end
						EV_LPC_TO_LH: begin
							lpc_q <= lpc_q - CNT_W'(1);
							lh_q  <= lh_q + CNT_W'(1);
						end
						EV_HPV_TO_HH: begin
							hpv_q <= hpv_q - CNT_W'(1);
							hh_q  <= hh_q + CNT_W'(1);
						end
						EV_LPR_TO_LH: begin
							lpr_q <= lpr_q - CNT_W'(1);
							lh_q  <= lh_q + CNT_W'(1);
						end
						EV_LGC_TO_LH: begin
							lgc_q <= lgc_q - CNT_W'(1);
							lh_q  <= lh_q + CNT_W'(1);
						end
						EV_HGC_TO_HH: begin
							hgc_q <= hgc_q - CNT_W'(1);
							hh_q  <= hh_q + CNT_W'(1);
						end
						EV_LGR_TO_LH: begin
							lgr_q <= lgr_q - CNT_W'(1);
							lh_q  <= lh_q + CNT_W'(1);
						end
						EV_HGR_TO_HH: begin
							hgr_q <= hgr_q - CNT_W'(1);
							hh_q  <= hh_q + CNT_W'(1);
						end
						default: ;
					endcase
				end
				SQ_STATUS: status_q <= status_new;
				default: ;
			endcase
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= in_word;
			tot_q  <= '0;
			ev_q   <= EV_NONE;
		end
		case (state_q)
			SQ_INIT: if (cnt_q == SEQ_W'(1)) nh_q <= mul_p[MB_W-1:0];
			SQ_PRE: begin
				case (cnt_q)
					SEQ_W'(1): cn_q <= mul_p[MB_W-1:0];
					SEQ_W'(2): wn_q <= mul_p[MB_W-1:0];
					SEQ_W'(3): kn_q <= mul_p[MB_W-1:0];
					default: ;
				endcase
			end
			SQ_TERM: begin
				if (cnt_q != SEQ_W'(0)) begin
					tot_q <= tot_next;
					cum_q[EV_W'(cnt_q - SEQ_W'(1))] <= tot_next;
				end
			end
			SQ_PROD: begin
				case (cnt_q)
					SEQ_W'(0): acc_q <= word_q[RW_W-1] ? (PROD_W'(tot_q) << RW_W) : '0;
					SEQ_W'(1): acc_q <= acc_q + PROD_W'(mul_p);
					default:   acc_q <= acc_q + (PROD_W'(mul_p) << (TOT_W/2));
				endcase
			end
			SQ_CMP: if (hit) ev_q <= ev_code_t'(cnt_q);
			default: ;
		endcase
		if (load_out) begin
			out_data_q <= {(M_TDATA_W-TOT_W-2*CNT_W-2-EV_W)'(0), tot_q,
				poor_sum[CNT_W-1:0], good_sum[CNT_W-1:0], status_q, ev_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: rtl/snc_checker.sv
// Port-level checks for the nest choice event engine, bound to the top level.
module snc_checker
	import snc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata
);

	// a result waiting for the sink holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// the engine goes busy right after taking a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while engine busy");

	// a fresh result is posted as the engine returns to idle
	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> s_axis_tready)
		else $error("result posted while engine still busy");

	// with a zero rate sum no event can be chosen
	a_no_event_zero_rate: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[73:26] == 48'd0) |-> m_axis_tdata[3:0] == EV_NONE)
		else $error("event reported with zero total rate");

endmodule

bind stochastic_nest_choice_step_unit snc_checker u_snc_checker (.*);
